/* rtl/afc_pkg.sv */
// Shared types and constants of the box versus view frustum classifier.
package afc_pkg;

  localparam int unsigned IdW        = 8;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned PlaneW     = 3;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ProdW      = 2 * CoordW;
  // Three products of at most 2^30 plus the scaled offset stay below 2^32.
  localparam int unsigned SumW       = ProdW + 1;
  localparam int unsigned DShift     = 12;
  localparam int unsigned NumPlanes  = 6;
  localparam int unsigned NumCorners = 8;

  localparam logic [PlaneW-1:0] ResetPlane = 3'd4;
  localparam logic [PlaneW-1:0] LastPlane  = 3'd5;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } afc_verdict_e;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_TEST   = 5'b01000,
    ST_FINISH = 5'b10000
  } afc_state_e;

  typedef struct packed {
    logic        [IdW-1:0]    object_id;
    logic signed [CoordW-1:0] box_xmin;
    logic signed [CoordW-1:0] box_ymin;
    logic signed [CoordW-1:0] box_zmin;
    logic signed [CoordW-1:0] box_xmax;
    logic signed [CoordW-1:0] box_ymax;
    logic signed [CoordW-1:0] box_zmax;
  } afc_in_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [PlaneW-1:0] deciding_plane;
  } afc_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] xmin;
    logic signed [CoordW-1:0] ymin;
    logic signed [CoordW-1:0] zmin;
    logic signed [CoordW-1:0] xmax;
    logic signed [CoordW-1:0] ymax;
    logic signed [CoordW-1:0] zmax;
  } afc_box_t;

  // Register layout: a in the low field, d in the high field.
  typedef struct packed {
    logic signed [CoordW-1:0] d;
    logic signed [CoordW-1:0] c;
    logic signed [CoordW-1:0] b;
    logic signed [CoordW-1:0] a;
  } afc_plane_t;

  typedef struct packed {
    logic              valid;
    logic [PlaneW-1:0] plane;
  } afc_issue_t;

  typedef struct packed {
    logic              valid;
    logic [PlaneW-1:0] plane;
    afc_verdict_e      verdict;
  } afc_res_t;

endpackage

/* rtl/aabb_frustum_cull_coherent.sv */
// Top level: plane registers, object store, plane evaluator and the test sequencer.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   afc_in_t  (object id and box)
//   out      output     out_valid_o/out_stall_i afc_out_t (verdict, deciding plane)
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Between input transfers the store is read, then the planes are tested one by one (the
// six-product stage and the corner sums of the evaluator) until one does not hold the box
// inside or all six do, and the sequencer returns to idle, where the next transfer is taken.
// After reset every store entry is swept to ResetPlane, and in_stall_o stays high until
// the sweep is done. A stalled result waits in the output register; the
// next item is taken meanwhile and only its own completion waits for the register.
module aabb_frustum_cull_coherent #(
  parameter int unsigned OBJECTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  afc_pkg::afc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output afc_pkg::afc_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [afc_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned IdxW   = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
  localparam int unsigned IdVals = 2 ** afc_pkg::IdW;
  localparam int unsigned PW     = afc_pkg::PlaneW;

  afc_pkg::afc_state_e state_q, state_d;
  afc_pkg::afc_plane_t plane_q [afc_pkg::NumPlanes];
  afc_pkg::afc_box_t   box_q, box_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [PW-1:0]       last_q, last_d;
  logic [PW-1:0]       ord_q, ord_d;
  logic [1:0]          verd_q, verd_d;
  logic [PW-1:0]       dplane_q, dplane_d;
  logic                out_valid_q, out_valid_d;
  afc_pkg::afc_out_t   out_data_q, out_data_d;

  logic [IdxW-1:0]     mod_tab [IdVals];
  logic                rd_en, wr_en, clearing;
  logic [PW-1:0]       rd_data, first_plane, next_plane, ord_m1;
  afc_pkg::afc_issue_t issue;
  afc_pkg::afc_res_t   res;
  afc_pkg::afc_plane_t coeff;
  logic                fin_valid, out_free;
  logic [1:0]          fin_verdict;
  logic [PW-1:0]       fin_plane;

  // Object ids wrap onto the store depth through a table worked out at elaboration.
  for (genvar g = 0; g < IdVals; g++) begin : g_mod
    assign mod_tab[g] = IdxW'(g % OBJECTS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afc_pkg::NumPlanes; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= afc_pkg::LastPlane)) begin
      plane_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  afc_store #(
    .Depth (OBJECTS),
    .AddrW (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (mod_tab[in_data_i.object_id]),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (idx_q),
    .wr_data_i  (fin_plane),
    .clearing_o (clearing)
  );

  assign coeff = plane_q[issue.plane];

  afc_plane_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .coeff_i (coeff),
    .box_i   (box_q),
    .res_o   (res)
  );

  // The remembered plane goes first; the rest follow in index order, skipping it.
  assign first_plane = (rd_data > afc_pkg::LastPlane) ? afc_pkg::ResetPlane : rd_data;
  assign ord_m1      = ord_q - PW'(1);
  assign next_plane  = (ord_m1 < last_q) ? ord_m1 : ord_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    box_d       = box_q;
    idx_d       = idx_q;
    last_d      = last_q;
    ord_d       = ord_q;
    verd_d      = verd_q;
    dplane_d    = dplane_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    issue       = '0;
    fin_valid   = 1'b0;
    fin_verdict = verd_q;
    fin_plane   = dplane_q;

    unique case (state_q)
      afc_pkg::ST_CLEAR: begin
        if (!clearing) begin
          state_d = afc_pkg::ST_IDLE;
        end
      end
      afc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          rd_en   = 1'b1;
          box_d   = '{xmin: in_data_i.box_xmin, ymin: in_data_i.box_ymin,
                      zmin: in_data_i.box_zmin, xmax: in_data_i.box_xmax,
                      ymax: in_data_i.box_ymax, zmax: in_data_i.box_zmax};
          idx_d   = mod_tab[in_data_i.object_id];
          state_d = afc_pkg::ST_LOAD;
        end
      end
      afc_pkg::ST_LOAD: begin
        last_d      = first_plane;
        issue.valid = 1'b1;
        issue.plane = first_plane;
        ord_d       = PW'(1);
        state_d     = afc_pkg::ST_TEST;
      end
      afc_pkg::ST_TEST: begin
        if (res.valid && (res.verdict != afc_pkg::VERDICT_INSIDE)) begin
          fin_valid   = 1'b1;
          fin_verdict = res.verdict;
          fin_plane   = res.plane;
        end else if (ord_q == PW'(afc_pkg::NumPlanes)) begin
          fin_valid   = 1'b1;
          fin_verdict = afc_pkg::VERDICT_INSIDE;
          fin_plane   = last_q;
        end else begin
          issue.valid = 1'b1;
          issue.plane = next_plane;
          ord_d       = ord_q + PW'(1);
        end
      end
      afc_pkg::ST_FINISH: begin
        fin_valid = 1'b1;
      end
      default: begin
        state_d = afc_pkg::ST_IDLE;
      end
    endcase

    if (fin_valid) begin
      verd_d   = fin_verdict;
      dplane_d = fin_plane;
      if (out_free) begin
        out_valid_d               = 1'b1;
        out_data_d.verdict        = fin_verdict;
        out_data_d.deciding_plane = fin_plane;
        wr_en                     = 1'b1;
        state_d                   = afc_pkg::ST_IDLE;
      end else begin
        state_d = afc_pkg::ST_FINISH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afc_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      ord_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ord_q       <= ord_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q      <= box_d;
    idx_q      <= idx_d;
    last_q     <= last_d;
    verd_q     <= verd_d;
    dplane_q   <= dplane_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != afc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_res_only_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (state_q == afc_pkg::ST_TEST))
    else $error("evaluator result outside the test phase");

  a_no_transfer_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("input open while the store is being cleared");

  a_store_write_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!clearing && out_free && (fin_plane <= afc_pkg::LastPlane)))
    else $error("store written at the wrong time or with a bad plane");

  a_result_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (out_valid_o && (out_data_o.deciding_plane == $past(fin_plane))))
    else $error("result does not match the plane written to the store");

endmodule

/* rtl/afc_store.sv */
// Per-object store of the last deciding plane, with a clearing sweep after reset.
module afc_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [afc_pkg::PlaneW-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [afc_pkg::PlaneW-1:0] wr_data_i,
  output logic                       clearing_o
);

  logic [afc_pkg::PlaneW-1:0] mem [Depth];
  logic [afc_pkg::PlaneW-1:0] rd_data_q;
  logic [AddrW-1:0]           clr_addr_q, clr_addr_d;
  logic                       clearing_q, clearing_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= afc_pkg::ResetPlane;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

/* rtl/afc_plane_eval.sv */
// Tests one plane against the eight box corners: a product stage, then sums and signs.
module afc_plane_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afc_pkg::afc_issue_t issue_i,
  input  afc_pkg::afc_plane_t coeff_i,
  input  afc_pkg::afc_box_t   box_i,
  output afc_pkg::afc_res_t   res_o
);

  localparam int unsigned SumW  = afc_pkg::SumW;
  localparam int unsigned ProdW = afc_pkg::ProdW;
  localparam int unsigned DW    = afc_pkg::CoordW + afc_pkg::DShift;

  // Each corner takes the min or max on every axis, so six products cover all eight.
  logic signed [ProdW-1:0]          prod_x_q [2];
  logic signed [ProdW-1:0]          prod_y_q [2];
  logic signed [ProdW-1:0]          prod_z_q [2];
  logic signed [afc_pkg::CoordW-1:0] d_q;
  logic                             valid_q;
  logic [afc_pkg::PlaneW-1:0]       plane_q;

  logic [afc_pkg::NumCorners-1:0] neg;
  logic [SumW-1:0]                d_ext;
  logic [SumW-1:0]                sum;
  logic [ProdW-1:0]               px, py, pz;

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      prod_x_q[0] <= $signed(coeff_i.a) * $signed(box_i.xmin);
      prod_x_q[1] <= $signed(coeff_i.a) * $signed(box_i.xmax);
      prod_y_q[0] <= $signed(coeff_i.b) * $signed(box_i.ymin);
      prod_y_q[1] <= $signed(coeff_i.b) * $signed(box_i.ymax);
      prod_z_q[0] <= $signed(coeff_i.c) * $signed(box_i.zmin);
      prod_z_q[1] <= $signed(coeff_i.c) * $signed(box_i.zmax);
      d_q         <= coeff_i.d;
      plane_q     <= issue_i.plane;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue_i.valid;
    end
  end

  always_comb begin
    d_ext = {{(SumW - DW){d_q[afc_pkg::CoordW-1]}}, d_q, {afc_pkg::DShift{1'b0}}};
    neg   = '0;
    sum   = '0;
    px    = '0;
    py    = '0;
    pz    = '0;
    for (int k = 0; k < afc_pkg::NumCorners; k++) begin
      px = ((k & 1) != 0) ? prod_x_q[1] : prod_x_q[0];
      py = ((k & 2) != 0) ? prod_y_q[1] : prod_y_q[0];
      pz = ((k & 4) != 0) ? prod_z_q[1] : prod_z_q[0];
      sum = {px[ProdW-1], px} + {py[ProdW-1], py} + {pz[ProdW-1], pz} + d_ext;
      neg[k] = sum[SumW-1];
    end
  end

  always_comb begin
    res_o.valid = valid_q;
    res_o.plane = plane_q;
    if (&neg) begin
      res_o.verdict = afc_pkg::VERDICT_OUTSIDE;
    end else if (|neg) begin
      res_o.verdict = afc_pkg::VERDICT_INTERSECT;
    end else begin
      res_o.verdict = afc_pkg::VERDICT_INSIDE;
    end
  end

endmodule
